// File: rtl/core/hpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpg_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_GEN    = 2'd1,
    REQ_SETPOS = 2'd2,
    REQ_NONE   = 2'd3
  } hpg_req_code_t;

  // Point sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_MUL,
    ST_OUT
  } hpg_state_t;

  // Radical-inverse unit states
  typedef enum logic [2:0] {
    RI_IDLE,
    RI_DIV,
    RI_ACC,
    RI_FRAC,
    RI_DONE
  } hpg_ri_state_t;

  // Control from the sequencer to the radical-inverse unit
  typedef struct packed {
    logic       start;
    logic [3:0] prime_idx;
  } hpg_ri_ctrl_t;

  localparam int NUM_PRIMES = 15;
  localparam int FRAC_BITS  = 32;
  localparam int DIV_STEP   = 4;   // quotient bits per cycle in the digit divider
  localparam int DIGIT_W    = 6;   // enough for the largest base (47)
  localparam logic [4:0] NUM_DIMS_RESET = 5'd2;

  // Base for dimension index modulo 15
  function automatic logic [DIGIT_W-1:0] prime_of(input logic [3:0] idx);
    logic [DIGIT_W-1:0] p;
    unique case (idx)
      4'd0:    p = 6'd2;
      4'd1:    p = 6'd3;
      4'd2:    p = 6'd5;
      4'd3:    p = 6'd7;
      4'd4:    p = 6'd11;
      4'd5:    p = 6'd13;
      4'd6:    p = 6'd17;
      4'd7:    p = 6'd19;
      4'd8:    p = 6'd23;
      4'd9:    p = 6'd29;
      4'd10:   p = 6'd31;
      4'd11:   p = 6'd37;
      4'd12:   p = 6'd41;
      4'd13:   p = 6'd43;
      4'd14:   p = 6'd47;
      default: p = 6'd2;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/hpg_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: bounds load, point generate, position set
interface hpg_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [3:0]         dim_index;
  logic signed [31:0] bound_low;
  logic signed [31:0] bound_high;
  logic [31:0]        position_value;

  modport source (
    output valid, req_type, dim_index, bound_low, bound_high, position_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, dim_index, bound_low, bound_high, position_value,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/hpg_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Result channel: one beat per dimension of a point
interface hpg_rsp_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_dim;
  logic [31:0]        unit_fraction;
  logic signed [31:0] coordinate;
  logic               last_of_point;

  modport source (
    output valid, out_dim, unit_fraction, coordinate, last_of_point,
    input  ready
  );

  modport sink (
    input  valid, out_dim, unit_fraction, coordinate, last_of_point,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/hpg_radinv.sv
`timescale 1ns / 1ps
`default_nettype none

// Radical inverse of n in a prime base, as floor(2^32 * num / den).
// Digits are peeled off by a shared divide-by-base unit (DIV_STEP bits a
// cycle), reversed into num while den collects base^k, then a restoring
// divider produces the 32 fraction bits one per cycle.
module hpg_radinv import hpg_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire hpg_ri_ctrl_t             ctrl,
  input  wire logic [POSITION_BITS-1:0] n,
  output logic                          done,
  output logic [FRAC_BITS-1:0]          frac
);

  localparam int DIV_ITERS = (POSITION_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int NP        = DIV_ITERS * DIV_STEP;
  localparam int DW        = POSITION_BITS + DIGIT_W;
  localparam logic [4:0] DIV_LAST  = 5'(DIV_ITERS - 1);
  localparam logic [4:0] FRAC_LAST = 5'(FRAC_BITS - 1);

  hpg_ri_state_t        state, state_next;
  logic [NP-1:0]        nq;
  logic [DIGIT_W-1:0]   rem;
  logic [DIGIT_W-1:0]   base;
  logic [DW-1:0]        num;
  logic [DW-1:0]        den;
  logic [4:0]           cnt;
  logic [FRAC_BITS-1:0] q;

  logic [DIGIT_W-1:0]   dv_rem;
  logic [DIGIT_W:0]     dv_try;
  logic [DIV_STEP-1:0]  dv_qbits;
  logic [NP-1:0]        nq_next;
  logic [DW:0]          fr_shift;
  logic [DW:0]          fr_sub;
  logic                 fr_ge;

  // Divide-by-base step: DIV_STEP quotient bits, remainder stays below base
  always_comb begin
    dv_rem   = rem;
    dv_try   = '0;
    dv_qbits = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      dv_try = {dv_rem, nq[NP-1-i]};
      if (dv_try >= {1'b0, base}) begin
        dv_try = dv_try - {1'b0, base};
        dv_qbits[DIV_STEP-1-i] = 1'b1;
      end
      dv_rem = dv_try[DIGIT_W-1:0];
    end
    nq_next = {nq[NP-DIV_STEP-1:0], dv_qbits};
  end

  // Fraction step: restoring division of num by den
  always_comb begin
    fr_shift = {num, 1'b0};
    fr_sub   = fr_shift - {1'b0, den};
    fr_ge    = fr_shift >= {1'b0, den};
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      RI_IDLE: begin
        if (ctrl.start) begin
          state_next = (n == '0) ? RI_FRAC : RI_DIV;
        end
      end
      RI_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = RI_ACC;
        end
      end
      RI_ACC: begin
        state_next = (nq == '0) ? RI_FRAC : RI_DIV;
      end
      RI_FRAC: begin
        if (cnt == FRAC_LAST) begin
          state_next = RI_DONE;
        end
      end
      RI_DONE: begin
        state_next = RI_IDLE;
      end
      default: state_next = RI_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (state == RI_DONE);
    frac = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RI_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      RI_IDLE: begin
        if (ctrl.start) begin
          nq   <= NP'(n);
          rem  <= '0;
          num  <= '0;
          den  <= DW'(1);
          base <= prime_of(ctrl.prime_idx);
          cnt  <= '0;
        end
      end
      RI_DIV: begin
        nq  <= nq_next;
        rem <= dv_rem;
        cnt <= cnt + 5'd1;
      end
      RI_ACC: begin
        // append the digit reversed, grow the denominator
        num <= num * DW'(base) + DW'(rem);
        den <= den * DW'(base);
        rem <= '0;
        cnt <= '0;
      end
      RI_FRAC: begin
        num <= fr_ge ? fr_sub[DW-1:0] : fr_shift[DW-1:0];
        q   <= {q[FRAC_BITS-2:0], fr_ge};
        cnt <= cnt + 5'd1;
      end
      RI_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/halton_point_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Halton point generator. A generate request (req_type 1) emits num_dims result
// beats, one per dimension, each with the radical inverse of position+1 in that
// dimension's prime base (a 0.32 fraction) and that fraction scaled into the
// dimension's stored bounds (signed Q16.16); the final beat carries
// last_of_point and the position then advances by one. Load (req_type 0) and
// position-set (req_type 2) requests give no beat; bounds and position reset
// to zero, num_dims to 2. The block works one request at a time. For each
// dimension one shared divider peels the base-b digits of the index, 4
// quotient bits per cycle, and a restoring divide then forms the 32 fraction
// bits. A finished beat waits in an output register while the next dimension
// is computed. The user must write num_dims only while no point is in
// progress; the block itself does not enforce this.
module halton_point_generator_top import hpg_pkg::*; #(
  parameter int MAX_DIMS      = 16,
  parameter int POSITION_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata,
  hpg_req_if.sink         req,
  hpg_rsp_if.source       rsp
);

  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PB = POSITION_BITS;

  hpg_state_t     state, state_next;
  logic [4:0]     num_dims;
  logic [PB-1:0]  position;

  // Bounds memory {high, low}, one write and one registered read port
  logic [63:0]         bnd_mem [MAX_DIMS];
  logic [MAX_DIMS-1:0] bnd_vld;
  logic [63:0]         rd_data;
  logic                rd_vld;

  logic [AW-1:0]  dim;
  logic [AW-1:0]  last_idx;
  logic [3:0]     pmod;
  logic           span_neg;
  logic [31:0]    span_mag;
  logic [31:0]    frac;
  logic [63:0]    prod;

  logic           rsp_valid_r;
  logic [3:0]     rsp_dim;
  logic [31:0]    rsp_frac;
  logic [31:0]    rsp_coord;
  logic           rsp_last;

  logic           req_beat;
  logic           mem_we;
  logic [AW-1:0]  wr_addr;
  logic           rd_en;
  logic           out_load;
  logic           is_last;
  hpg_ri_ctrl_t   ri_ctrl;
  logic           ri_done;
  logic [31:0]    ri_frac;
  logic [PB-1:0]  seq_n;
  logic [31:0]    lo_eff;
  logic [31:0]    hi_eff;
  logic [32:0]    span;
  logic [32:0]    span_abs;
  logic [31:0]    term;
  logic [31:0]    coord;
  logic [4:0]     nd_min1;
  logic [31:0]    eff_dims;
  logic [AW-1:0]  last_idx_c;

  hpg_radinv #(
    .POSITION_BITS(PB)
  ) u_radinv (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ri_ctrl),
    .n    (seq_n),
    .done (ri_done),
    .frac (ri_frac)
  );

  // Request decode
  always_comb begin
    req_beat = req.valid && req.ready;
    wr_addr  = AW'(req.dim_index);
    mem_we   = req_beat && (req.req_type == REQ_LOAD) &&
               (32'(req.dim_index) < 32'(MAX_DIMS));
    seq_n    = position + PB'(1);
  end

  // Effective dimension count: zero reads as one, clamp at MAX_DIMS
  always_comb begin
    nd_min1  = (num_dims == 5'd0) ? 5'd1 : num_dims;
    eff_dims = (32'(nd_min1) > 32'(MAX_DIMS)) ? 32'(MAX_DIMS) : 32'(nd_min1);
    last_idx_c = AW'(eff_dims - 32'd1);
  end

  // Bounds of the current dimension; an unwritten entry reads as zero
  always_comb begin
    lo_eff   = rd_vld ? rd_data[31:0]  : 32'd0;
    hi_eff   = rd_vld ? rd_data[63:32] : 32'd0;
    span     = {hi_eff[31], hi_eff} - {lo_eff[31], lo_eff};
    span_abs = span[32] ? (33'd0 - span) : span;
  end

  // Coordinate: low plus the span term truncated toward zero
  always_comb begin
    term    = span_neg ? (32'd0 - prod[63:32]) : prod[63:32];
    coord   = lo_eff + term;
    is_last = (dim == last_idx);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_beat && req.req_type == REQ_GEN) begin
          state_next = ST_START;
        end
      end
      ST_START: state_next = ST_WAIT;
      ST_WAIT: begin
        if (ri_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = is_last ? ST_IDLE : ST_START;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req.ready         = (state == ST_IDLE);
    rd_en             = (state == ST_START);
    ri_ctrl.start     = (state == ST_START);
    ri_ctrl.prime_idx = pmod;
    out_load          = (state == ST_OUT) && (!rsp_valid_r || rsp.ready);
  end

  always_comb begin
    rsp.valid         = rsp_valid_r;
    rsp.out_dim       = rsp_dim;
    rsp.unit_fraction = rsp_frac;
    rsp.coordinate    = rsp_coord;
    rsp.last_of_point = rsp_last;
  end

  // Bounds memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bnd_mem[wr_addr] <= {req.bound_high, req.bound_low};
    end
    if (rd_en) begin
      rd_data <= bnd_mem[dim];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (mem_we) begin
        bnd_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= bnd_vld[dim];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      num_dims    <= NUM_DIMS_RESET;
      position    <= '0;
      rsp_valid_r <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        num_dims <= cfg_wdata;
      end
      if (req_beat && req.req_type == REQ_SETPOS) begin
        position <= PB'(req.position_value);
      end else if (out_load && is_last) begin
        position <= seq_n;
      end
      if (out_load) begin
        rsp_valid_r <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_r <= 1'b0;
      end
    end
  end

  // Point datapath
  always_ff @(posedge clk) begin
    if (req_beat && req.req_type == REQ_GEN) begin
      dim      <= '0;
      pmod     <= '0;
      last_idx <= last_idx_c;
    end
    if (state == ST_WAIT) begin
      span_neg <= span[32];
      span_mag <= span_abs[31:0];
      if (ri_done) begin
        frac <= ri_frac;
      end
    end
    if (state == ST_MUL) begin
      prod <= 64'(frac) * 64'(span_mag);
    end
    if (out_load) begin
      rsp_dim   <= 4'(dim);
      rsp_frac  <= frac;
      rsp_coord <= coord;
      rsp_last  <= is_last;
      dim       <= dim + AW'(1);
      pmod      <= (pmod == 4'(NUM_PRIMES - 1)) ? 4'd0 : pmod + 4'd1;
    end
  end

  // The radical-inverse unit only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    ri_done |-> state == ST_WAIT)
    else $error("radical inverse finished outside the wait state");

  // Finishing a point advances the position and frees the request side
  a_point_end: assert property (@(posedge clk) disable iff (rst)
    (out_load && is_last) |=> (position == $past(position) + PB'(1)) && state == ST_IDLE)
    else $error("position did not advance at end of point");

  // Position holds while a point is in progress
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && !(out_load && is_last)) |=> $stable(position))
    else $error("position changed during a point");

endmodule

`default_nettype wire
